// ----- rtl/pffa_pkg.sv -----
// shared types, defaults and operation codes of the page frame allocator
package pffa_pkg;

	localparam int NUM_PAGES_DEF  = 128;
	localparam int PAGE_SHIFT_DEF = 21;

	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] page_count;
		logic [7:0] chain_head;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [6:0]  first_page;
		logic [27:0] first_address;
	} rsp_t;

endpackage

// ----- rtl/pffa_ram.sv -----
// generic single write port ram with registered read
module pffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/page_frame_free_list_allocator_unit.sv -----
// Page frame allocator: a free list of NUM_PAGES frames kept as next links in one ram plus a
// head register. One request is handled at a time; the pace is set by the single link ram,
// which is followed one entry per cycle. Allocate walks the list for min(page_count,
// NUM_PAGES, free pages) pages, free walks the chain to its tail; count zero, empty list, no
// chain and unknown kinds go straight to finish. Reinitialize rewrites every link. After
// reset the same pass rebuilds the list while req_stall is high. A finished response waits
// in its own register, so the next request is taken while it is still stalled.
module page_frame_free_list_allocator_unit #(
	parameter int NUM_PAGES  = pffa_pkg::NUM_PAGES_DEF,
	parameter int PAGE_SHIFT = pffa_pkg::PAGE_SHIFT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pffa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pffa_pkg::rsp_t rsp
);

	import pffa_pkg::*;

	localparam int IW = $clog2(NUM_PAGES);
	localparam int LW = $clog2(NUM_PAGES + 1);
	localparam logic [LW-1:0] NIL  = LW'(NUM_PAGES);
	localparam logic [IW-1:0] LAST = IW'(NUM_PAGES - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_AWALK = 3'd2;
	localparam logic [2:0] ST_FWALK = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]    state_q;
	logic [LW-1:0] head_q;
	logic [IW-1:0] sweep_q;
	logic          report_q;
	logic          rsp_valid_q;
	logic [IW-1:0] tail_q;
	logic [7:0]    rem_q;
	logic [IW-1:0] steps_q;
	logic [LW-1:0] chain_q;
	rsp_t          res_q;
	rsp_t          rsp_q;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [LW-1:0] wr_data;
	logic [IW-1:0] rd_addr;
	logic [LW-1:0] rd_data;

	logic          d_nil;
	logic          head_nil;
	logic          chain_ok;
	logic          a_stop;
	logic [7:0]    want_m1;
	logic          slot_free;

	pffa_ram #(
		.WIDTH(LW),
		.DEPTH(NUM_PAGES)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign d_nil     = rd_data >= NIL;
	assign head_nil  = head_q >= NIL;
	assign chain_ok  = 32'(req.chain_head) < NUM_PAGES;
	assign a_stop    = (rem_q == 8'd0) || d_nil;
	// counts above the pool size saturate
	assign want_m1   = (32'(req.page_count) > NUM_PAGES) ? 8'(NUM_PAGES - 1)
	                                                     : req.page_count - 8'd1;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_data = NIL;
		rd_addr = rd_data[IW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = (req.kind == KIND_FREE) ? IW'(req.chain_head) : head_q[IW-1:0];
			end
			ST_SWEEP: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = LW'({1'b0, sweep_q} + {{IW{1'b0}}, 1'b1});
			end
			ST_AWALK: begin
				// cut the granted run off behind its last page
				wr_en = a_stop;
			end
			ST_FWALK: begin
				// splice the chain tail onto the old free list
				wr_en   = d_nil;
				wr_data = head_q;
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			head_q   <= '0;
			sweep_q  <= '0;
			report_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (req.kind)
							KIND_INIT: begin
								sweep_q  <= '0;
								report_q <= 1'b1;
								state_q  <= ST_SWEEP;
							end
							KIND_ALLOC: begin
								if (req.page_count == 8'd0 || head_nil) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_AWALK;
								end
							end
							KIND_FREE: begin
								state_q <= chain_ok ? ST_FWALK : ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + {{(IW-1){1'b0}}, 1'b1};
					if (sweep_q == LAST) begin
						head_q  <= '0;
						state_q <= report_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_AWALK: begin
					if (a_stop) begin
						head_q  <= d_nil ? NIL : rd_data;
						state_q <= ST_FIN;
					end
				end
				ST_FWALK: begin
					if (d_nil) begin
						head_q  <= chain_q;
						state_q <= ST_FIN;
					end else if (steps_q == LAST) begin
						// no tail found: the chain loops
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// response slot: filled from finish, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				res_q   <= '0;
				tail_q  <= (req.kind == KIND_FREE) ? IW'(req.chain_head) : head_q[IW-1:0];
				rem_q   <= want_m1;
				steps_q <= '0;
				chain_q <= LW'(req.chain_head);
			end
			ST_SWEEP: begin
				res_q <= '0;
			end
			ST_AWALK: begin
				if (a_stop) begin
					res_q.ok            <= 1'b1;
					res_q.first_page    <= 7'(head_q);
					res_q.first_address <= 28'(head_q) << PAGE_SHIFT;
				end else begin
					tail_q <= rd_data[IW-1:0];
					rem_q  <= rem_q - 8'd1;
				end
			end
			ST_FWALK: begin
				if (d_nil) begin
					res_q.ok <= 1'b1;
				end else begin
					tail_q  <= rd_data[IW-1:0];
					steps_q <= steps_q + {{(IW-1){1'b0}}, 1'b1};
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.first_page == 7'd0 && rsp.first_address == 28'd0)
		else $error("failed request carries a nonzero page");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("response raised outside finish");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && slot_free |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("finished request not delivered");

	a_sweep_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && sweep_q == LAST |=> head_q == '0)
		else $error("rebuilt list does not start at page zero");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_SWEEP || state_q == ST_AWALK || state_q == ST_FWALK)
		else $error("link write outside a walk or sweep");
`endif

endmodule

// ----- sim/page_frame_allocator_checker.sv -----
// checker of the page frame allocator: mirrors the free list and compares every response
module page_frame_allocator_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  pffa_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  pffa_pkg::rsp_t rsp,
	output int             mismatches,
	output int             outstanding
);

	import pffa_pkg::*;

	localparam logic [7:0] NIL = 8'(NUM_PAGES_DEF);

	logic [7:0] link_mem [NUM_PAGES_DEF];
	logic [7:0] head_page;
	rsp_t       expected_grants [$];
	rsp_t       oldest;

	function automatic void rebuild_list();
		int i;
		for (i = 0; i < NUM_PAGES_DEF; i++)
			link_mem[i] = 8'(i + 1);
		head_page = 8'd0;
	endfunction

	function automatic rsp_t take_pages(logic [7:0] count);
		rsp_t       grant;
		logic [7:0] tail;
		int         want;
		int         i;
		grant = '0;
		if (count == 8'd0 || head_page >= NIL)
			return grant;
		want = (count > NUM_PAGES_DEF) ? NUM_PAGES_DEF : int'(count);
		tail = head_page;
		for (i = 1; i < want && link_mem[tail] < NIL; i++)
			tail = link_mem[tail];
		grant.ok            = 1'b1;
		grant.first_page    = head_page[6:0];
		grant.first_address = 28'(head_page) << PAGE_SHIFT_DEF;
		// detach the granted run, anything at or above the pool size is a null link
		head_page      = (link_mem[tail] >= NIL) ? NIL : link_mem[tail];
		link_mem[tail] = NIL;
		return grant;
	endfunction

	function automatic rsp_t return_chain(logic [7:0] chain);
		rsp_t       result;
		logic [7:0] tail;
		int         steps;
		result = '0;
		if (chain >= NIL)
			return result;
		tail = chain;
		for (steps = 0; steps < NUM_PAGES_DEF; steps++) begin
			if (link_mem[tail] >= NIL) begin
				link_mem[tail] = head_page;
				head_page      = chain;
				result.ok      = 1'b1;
				return result;
			end
			tail = link_mem[tail];
		end
		// no tail within the pool size: the chain loops, left alone
		return result;
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t result;
		result = '0;
		case (r.kind)
			KIND_INIT:  rebuild_list();
			KIND_ALLOC: result = take_pages(r.page_count);
			KIND_FREE:  result = return_chain(r.chain_head);
			default:    ;
		endcase
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rebuild_list();
			expected_grants.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_grants.size() == 0) begin
					$error("response with no request outstanding: ok %0d page %0d addr %0h",
						rsp.ok, rsp.first_page, rsp.first_address);
					mismatches++;
				end else begin
					oldest = expected_grants.pop_front();
					if (rsp.ok !== oldest.ok) begin
						$error("ok: expected %0d, got %0d", oldest.ok, rsp.ok);
						mismatches++;
					end
					if (rsp.first_page !== oldest.first_page) begin
						$error("first_page: expected %0d, got %0d", oldest.first_page,
							rsp.first_page);
						mismatches++;
					end
					if (rsp.first_address !== oldest.first_address) begin
						$error("first_address: expected %0h, got %0h", oldest.first_address,
							rsp.first_address);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_grants.push_back(predict_response(req));
			outstanding = expected_grants.size();
		end
	end

endmodule

// ----- sim/page_frame_free_list_allocator_unit_tb.sv -----
// testbench top of the page frame allocator: clock, reset, request stimulus and verdict
module page_frame_free_list_allocator_unit_tb;
	import pffa_pkg::*;

	localparam logic [1:0] KIND_UNUSED     = 2'd3;
	localparam int         RANDOM_REQUESTS = 950;

	logic clk       = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;

	int         send_idle_pct  = 17;
	int         recv_stall_pct = 71;
	logic [6:0] owned_pages [$];
	logic [1:0] issued_kinds [$];
	logic [1:0] answered_kind;

	page_frame_free_list_allocator_unit dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	page_frame_allocator_checker grant_checker (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.mismatches,
		.outstanding
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// keep track of granted chains so most frees hand back real allocations
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall && issued_kinds.size() != 0) begin
				answered_kind = issued_kinds.pop_front();
				if (answered_kind == KIND_ALLOC && rsp.ok)
					owned_pages.push_back(rsp.first_page);
			end
			if (req_valid && !req_stall)
				issued_kinds.push_back(req.kind);
		end
	end

	function automatic req_t make_request(logic [1:0] kind, logic [7:0] count, logic [7:0] chain);
		req_t r;
		r.kind       = kind;
		r.page_count = count;
		r.chain_head = chain;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   roll;
		int   pick;
		r.kind       = KIND_ALLOC;
		r.page_count = 8'($urandom);
		r.chain_head = 8'($urandom);
		roll = $urandom_range(99);
		if (roll < 4) begin
			r.kind = KIND_INIT;
			owned_pages.delete();
		end else if (roll < 7) begin
			r.kind = KIND_UNUSED;
		end else if (roll < 52) begin
			// mostly small grants so the list lasts, now and then a huge one
			if ($urandom_range(9) != 0)
				r.page_count = 8'($urandom_range(1, 6));
		end else begin
			r.kind = KIND_FREE;
			if (owned_pages.size() != 0 && $urandom_range(9) != 0) begin
				pick         = $urandom_range(owned_pages.size() - 1);
				r.chain_head = {1'b0, owned_pages[pick]};
				owned_pages.delete(pick);
			end
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		req_t directed [$];
		int   i;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		directed.push_back(make_request(KIND_ALLOC, 8'd0, 8'd0));     // zero count
		directed.push_back(make_request(KIND_ALLOC, 8'd1, 8'd0));
		directed.push_back(make_request(KIND_ALLOC, 8'd5, 8'd255));
		directed.push_back(make_request(KIND_FREE, 8'd255, 8'd0));
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd128));    // no chain
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd255));
		directed.push_back(make_request(KIND_ALLOC, 8'd255, 8'd0));   // more than left
		directed.push_back(make_request(KIND_ALLOC, 8'd1, 8'd0));     // empty list
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd1));
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd0));
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd0));      // double free, loops
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd3));      // cyclic chain
		directed.push_back(make_request(KIND_ALLOC, 8'd2, 8'd0));
		directed.push_back(make_request(KIND_UNUSED, 8'd255, 8'd255));
		directed.push_back(make_request(KIND_INIT, 8'd255, 8'd255));
		directed.push_back(make_request(KIND_ALLOC, 8'd128, 8'd0));   // exactly the pool
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd0));
		directed.push_back(make_request(KIND_ALLOC, 8'd129, 8'd0));   // saturates
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd0));
		directed.push_back(make_request(KIND_ALLOC, 8'd3, 8'd0));
		directed.push_back(make_request(KIND_ALLOC, 8'd124, 8'd0));
		directed.push_back(make_request(KIND_FREE, 8'd0, 8'd127));
		directed.push_back(make_request(KIND_ALLOC, 8'd1, 8'd0));     // last page of the pool
		directed.push_back(make_request(KIND_INIT, 8'd0, 8'd0));

		foreach (directed[n])
			send_request(directed[n]);
		wait_drained();

		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS / 3) begin
				wait_drained();
				send_idle_pct  = 71;
				recv_stall_pct = 17;
			end
			if (i == 2 * RANDOM_REQUESTS / 3) begin
				wait_drained();
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			send_request(random_request());
		end
		wait_drained();
		repeat (NUM_PAGES_DEF + 8) @(negedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
